### hw/rtl/rfe_pkg.sv
// Shared types, constants and helpers for the RTC-fields-to-epoch converter.
package rfe_pkg;

  // Pipeline depth of each part and of the whole datapath.
  localparam int unsigned DecodeStages = 3;
  localparam int unsigned CivilStages  = 4;
  localparam int unsigned ScaleStages  = 3;
  localparam int unsigned NumStages    = DecodeStages + CivilStages + ScaleStages;

  // Widths of the intermediate and result values.
  localparam int unsigned ByteW  = 8;
  localparam int unsigned YearW  = 16;
  localparam int unsigned DaysW  = 25;
  localparam int unsigned HmsW   = 20;
  localparam int unsigned TotalW = 41;
  localparam int unsigned SecW   = 40;
  localparam int unsigned NanosW = 64;
  localparam int unsigned CfgW   = 8;
  localparam int unsigned AddrW  = 2;

  // Register reset values and fixed numbers of the calendar math.
  localparam logic [ByteW-1:0] YearAdjustReset = 8'd4;
  localparam logic [ByteW-1:0] DefaultCentury  = 8'd20;
  localparam logic [29:0]      NanosPerSec     = 30'd1000000000;

  // Configuration register indexes.
  typedef enum logic [AddrW-1:0] {
    CfgBinaryMode     = 2'd0,
    CfgCenturyPresent = 2'd1,
    CfgYearAdjust     = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic             binary_mode;
    logic             century_present;
    logic [ByteW-1:0] year_adjust;
  } cfg_t;

  // One set of RTC register bytes, raw or decoded.
  typedef struct packed {
    logic [ByteW-1:0] sec;
    logic [ByteW-1:0] min;
    logic [ByteW-1:0] hr;
    logic [ByteW-1:0] day;
    logic [ByteW-1:0] mon;
    logic [ByteW-1:0] yr;
    logic [ByteW-1:0] cen;
  } rtc_bytes_t;

  // Full year (already moved back for January and February) plus the
  // month term 153 * mp + 2 of the days-from-civil algorithm.
  typedef struct packed {
    logic signed [YearW-1:0] year;
    logic [15:0]             mp_term;
    logic [ByteW-1:0]        day;
    logic [ByteW-1:0]        hr;
    logic [ByteW-1:0]        min;
    logic [ByteW-1:0]        sec;
  } date_t;

  // Day count since 1970-01-01 and the seconds within the day.
  typedef struct packed {
    logic signed [DaysW-1:0] days;
    logic [HmsW-1:0]         hms;
  } day_count_t;

  // BCD decode adds the tens digit times ten; nibbles above 9 pass unchecked.
  function automatic logic [ByteW-1:0] decode_byte(logic [ByteW-1:0] b, logic binary);
    logic [ByteW-1:0] tens;
    logic [ByteW-1:0] ones;
    tens = {4'b0, b[7:4]};
    ones = {4'b0, b[3:0]};
    if (binary) begin
      return b;
    end
    return (tens << 3) + (tens << 1) + ones;
  endfunction

endpackage

### hw/rtl/rfe_decode.sv
// Byte decode and full-year assembly stages of the converter.
module rfe_decode (
  input  logic                                    clk_i,
  input  logic [rfe_pkg::DecodeStages-1:0]        en_i,
  input  rfe_pkg::cfg_t                           cfg_i,
  input  rfe_pkg::rtc_bytes_t                     raw_i,
  output rfe_pkg::date_t                          date_o
);

  rfe_pkg::rtc_bytes_t raw_q;
  rfe_pkg::rtc_bytes_t dec_d, dec_q;
  rfe_pkg::date_t      date_d, date_q;

  logic                         mon_early;
  logic [rfe_pkg::YearW-1:0]    cent_x100;
  logic [rfe_pkg::YearW-1:0]    year_sum;
  logic [rfe_pkg::ByteW-1:0]    mp;

  // Decode every byte; the century falls back to 20 when its byte is absent.
  always_comb begin
    dec_d.sec = rfe_pkg::decode_byte(raw_q.sec, cfg_i.binary_mode);
    dec_d.min = rfe_pkg::decode_byte(raw_q.min, cfg_i.binary_mode);
    dec_d.hr  = rfe_pkg::decode_byte(raw_q.hr,  cfg_i.binary_mode);
    dec_d.day = rfe_pkg::decode_byte(raw_q.day, cfg_i.binary_mode);
    dec_d.mon = rfe_pkg::decode_byte(raw_q.mon, cfg_i.binary_mode);
    dec_d.yr  = rfe_pkg::decode_byte(raw_q.yr,  cfg_i.binary_mode);
    dec_d.cen = cfg_i.century_present ? rfe_pkg::decode_byte(raw_q.cen, cfg_i.binary_mode)
                                      : rfe_pkg::DefaultCentury;
  end

  // Full year, shifted back one for months up to February, and the month term.
  always_comb begin
    mon_early       = (dec_q.mon <= 8'd2);
    cent_x100       = 16'(dec_q.cen) * 16'd100;
    year_sum        = 16'(dec_q.yr) + 16'(cfg_i.year_adjust) + cent_x100 - 16'(mon_early);
    mp              = mon_early ? (dec_q.mon + 8'd9) : (dec_q.mon - 8'd3);
    date_d.year     = $signed(year_sum);
    date_d.mp_term  = 16'(mp) * 16'd153 + 16'd2;
    date_d.day      = dec_q.day;
    date_d.hr       = dec_q.hr;
    date_d.min      = dec_q.min;
    date_d.sec      = dec_q.sec;
  end

  // Payload registers advance with their stage enables.
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      raw_q <= raw_i;
    end
    if (en_i[1]) begin
      dec_q <= dec_d;
    end
    if (en_i[2]) begin
      date_q <= date_d;
    end
  end

  assign date_o = date_q;

endmodule

### hw/rtl/rfe_civil.sv
// Days-from-civil stages: era split, day of era and day count since 1970.
module rfe_civil (
  input  logic                              clk_i,
  input  logic [rfe_pkg::CivilStages-1:0]   en_i,
  input  rfe_pkg::date_t                    date_i,
  output rfe_pkg::day_count_t               count_o
);

  // Reciprocals: n / 25 for n below 1626, v / 5 for v below 2^16.
  localparam logic [11:0] Recip25 = 12'd2622;
  localparam logic [15:0] Recip5  = 16'd52429;

  // Stage A: era and raw day-of-year quotient.
  logic [10:0]                   yr_div16;
  logic [22:0]                   div25_prod;
  logic [6:0]                    yr_div400;
  logic [31:0]                   doy_prod;
  logic signed [7:0]             era_a_d, era_a_q;
  logic signed [rfe_pkg::YearW-1:0] year_a_q;
  logic [12:0]                   doyq_a_d, doyq_a_q;
  logic [rfe_pkg::ByteW-1:0]     day_a_q;
  logic [rfe_pkg::HmsW-1:0]      hms_a_d, hms_a_q;

  // Stage B: year of era and day of year.
  logic signed [15:0]            era_ext;
  logic signed [15:0]            era400;
  logic signed [15:0]            yoe_full;
  logic [8:0]                    yoe_b_q;
  logic signed [7:0]             era_b_q;
  logic signed [13:0]            doy_b_d, doy_b_q;
  logic [rfe_pkg::HmsW-1:0]      hms_b_q;

  // Stage C: day of era and era start.
  logic [17:0]                   yoe365;
  logic [1:0]                    yoe_cent;
  logic signed [18:0]            doe_c_d, doe_c_q;
  logic signed [rfe_pkg::DaysW-1:0] era146_c_d, era146_c_q;
  logic [rfe_pkg::HmsW-1:0]      hms_c_q;

  // Stage D: day count.
  rfe_pkg::day_count_t           count_d, count_q;

  // Floor of year / 400; the only negative year is -1, which lands in era -1.
  always_comb begin
    yr_div16   = date_i.year[14:4];
    div25_prod = 23'(yr_div16) * 23'(Recip25);
    yr_div400  = div25_prod[22:16];
    era_a_d    = date_i.year[15] ? -8'sd1 : $signed({1'b0, yr_div400});
    doy_prod   = 32'(date_i.mp_term) * 32'(Recip5);
    doyq_a_d   = doy_prod[30:18];
    hms_a_d    = 20'(date_i.hr) * 20'd3600 + 20'(date_i.min) * 20'd60 + 20'(date_i.sec);
  end

  // Year of era and day of year, which reaches -1 for day zero in March.
  always_comb begin
    era_ext  = {{8{era_a_q[7]}}, era_a_q};
    era400   = era_ext * 16'sd400;
    yoe_full = year_a_q - era400;
    doy_b_d  = $signed({1'b0, doyq_a_q}) + $signed({6'b0, day_a_q}) - 14'sd1;
  end

  // Day of era with the leap-year corrections; yoe stays below 400.
  always_comb begin
    yoe365 = 18'(yoe_b_q) * 18'd365;
    if (yoe_b_q >= 9'd300) begin
      yoe_cent = 2'd3;
    end else if (yoe_b_q >= 9'd200) begin
      yoe_cent = 2'd2;
    end else if (yoe_b_q >= 9'd100) begin
      yoe_cent = 2'd1;
    end else begin
      yoe_cent = 2'd0;
    end
    doe_c_d    = $signed({1'b0, yoe365}) + $signed({12'b0, yoe_b_q[8:2]})
               - $signed({17'b0, yoe_cent}) + {{5{doy_b_q[13]}}, doy_b_q};
    era146_c_d = $signed({{17{era_b_q[7]}}, era_b_q}) * 25'sd146097;
  end

  // Shift the count so that 1970-01-01 is day zero.
  always_comb begin
    count_d.days = era146_c_q + {{6{doe_c_q[18]}}, doe_c_q} - 25'sd719468;
    count_d.hms  = hms_c_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      era_a_q  <= era_a_d;
      year_a_q <= date_i.year;
      doyq_a_q <= doyq_a_d;
      day_a_q  <= date_i.day;
      hms_a_q  <= hms_a_d;
    end
    if (en_i[1]) begin
      yoe_b_q <= yoe_full[8:0];
      era_b_q <= era_a_q;
      doy_b_q <= doy_b_d;
      hms_b_q <= hms_a_q;
    end
    if (en_i[2]) begin
      doe_c_q    <= doe_c_d;
      era146_c_q <= era146_c_d;
      hms_c_q    <= hms_b_q;
    end
    if (en_i[3]) begin
      count_q <= count_d;
    end
  end

  assign count_o = count_q;

endmodule

### hw/rtl/rfe_scale.sv
// Seconds assembly and the wrapped scaling to nanoseconds.
module rfe_scale (
  input  logic                                  clk_i,
  input  logic [rfe_pkg::ScaleStages-1:0]       en_i,
  input  rfe_pkg::day_count_t                   count_i,
  output logic signed [rfe_pkg::SecW-1:0]       seconds_o,
  output logic signed [rfe_pkg::NanosW-1:0]     nanos_o
);

  // The 41-bit total is split into a low unsigned and a high signed part.
  localparam int unsigned SplitW = 21;
  localparam int unsigned HighW  = rfe_pkg::TotalW - SplitW;
  localparam int unsigned LoProdW = SplitW + 30;
  localparam int unsigned HiProdW = rfe_pkg::NanosW - SplitW;

  logic signed [rfe_pkg::TotalW-1:0] total_d, total_q;
  logic [SplitW-1:0]                 total_lo;
  logic [HighW-1:0]                  total_hi;
  logic [LoProdW-1:0]                plo_d, plo_q;
  logic [HiProdW-1:0]                phi_d, phi_q;
  logic [rfe_pkg::SecW-1:0]          sec_q;
  logic [rfe_pkg::NanosW-1:0]        nanos_d, nanos_q;
  logic [rfe_pkg::SecW-1:0]          sec_out_q;

  // Seconds since the epoch.
  always_comb begin
    total_d = $signed({{(rfe_pkg::TotalW - rfe_pkg::DaysW){count_i.days[rfe_pkg::DaysW-1]}},
                       count_i.days}) * 41'sd86400
            + $signed({{(rfe_pkg::TotalW - rfe_pkg::HmsW){1'b0}}, count_i.hms});
  end

  // Two partial products of total * 10^9, kept modulo 2^64.
  always_comb begin
    total_lo = total_q[SplitW-1:0];
    total_hi = total_q[rfe_pkg::TotalW-1:SplitW];
    plo_d    = LoProdW'(total_lo) * LoProdW'(rfe_pkg::NanosPerSec);
    phi_d    = {{(HiProdW - HighW){total_hi[HighW-1]}}, total_hi}
             * HiProdW'(rfe_pkg::NanosPerSec);
    nanos_d  = rfe_pkg::NanosW'(plo_q) + {phi_q, {SplitW{1'b0}}};
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      total_q <= total_d;
    end
    if (en_i[1]) begin
      plo_q <= plo_d;
      phi_q <= phi_d;
      sec_q <= total_q[rfe_pkg::SecW-1:0];
    end
    if (en_i[2]) begin
      nanos_q   <= nanos_d;
      sec_out_q <= sec_q;
    end
  end

  assign seconds_o = $signed(sec_out_q);
  assign nanos_o   = $signed(nanos_q);

endmodule

### hw/rtl/rtc_fields_to_epoch_seconds.sv
// Top level of the RTC register bytes to Unix epoch seconds converter.
// Each input beat carries one set of raw RTC bytes and yields exactly one
// result beat with the epoch seconds (40-bit signed) and those seconds times
// 10^9 wrapped to 64 bits. Hours are read as 24-hour, bytes are BCD unless
// binary mode is set, and the century is 20 unless the century byte is
// enabled. The datapath is a ten-register pipeline whose first register
// loads at the accepting edge, and one beat is taken every cycle while
// the input is ready; each stage holds its item while the next one cannot
// take it, so a stalled output only stops the input once all stages are
// occupied. The user must write the registers through the configuration
// port only while no beat is in flight; the block itself does not enforce this.
module rtc_fields_to_epoch_seconds (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [rfe_pkg::AddrW-1:0]              cfg_addr_i,
  input  logic [rfe_pkg::CfgW-1:0]               cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [rfe_pkg::ByteW-1:0]              raw_seconds_i,
  input  logic [rfe_pkg::ByteW-1:0]              raw_minutes_i,
  input  logic [rfe_pkg::ByteW-1:0]              raw_hours_i,
  input  logic [rfe_pkg::ByteW-1:0]              raw_day_i,
  input  logic [rfe_pkg::ByteW-1:0]              raw_month_i,
  input  logic [rfe_pkg::ByteW-1:0]              raw_year_i,
  input  logic [rfe_pkg::ByteW-1:0]              raw_century_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [rfe_pkg::SecW-1:0]        epoch_seconds_o,
  output logic signed [rfe_pkg::NanosW-1:0]      epoch_scaled_nanos_o
);

  localparam int unsigned CivilLo = rfe_pkg::DecodeStages;
  localparam int unsigned ScaleLo = rfe_pkg::DecodeStages + rfe_pkg::CivilStages;

  rfe_pkg::cfg_t                   cfg_q;
  rfe_pkg::rtc_bytes_t             raw_beat;
  rfe_pkg::date_t                  date;
  rfe_pkg::day_count_t             day_count;
  logic [rfe_pkg::NumStages-1:0]   valid_q;
  logic [rfe_pkg::NumStages-1:0]   stage_en;

  // Configuration registers; writes to an unused index are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.binary_mode     <= 1'b0;
      cfg_q.century_present <= 1'b0;
      cfg_q.year_adjust     <= rfe_pkg::YearAdjustReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        rfe_pkg::CfgBinaryMode: begin
          cfg_q.binary_mode <= cfg_wdata_i[0];
        end
        rfe_pkg::CfgCenturyPresent: begin
          cfg_q.century_present <= cfg_wdata_i[0];
        end
        rfe_pkg::CfgYearAdjust: begin
          cfg_q.year_adjust <= cfg_wdata_i;
        end
        default: begin
        end
      endcase
    end
  end

  // A stage may load when it is empty or its content moves on.
  assign stage_en[rfe_pkg::NumStages-1] = !valid_q[rfe_pkg::NumStages-1] || out_ready_i;
  for (genvar s = 0; s < rfe_pkg::NumStages - 1; s++) begin : g_en
    assign stage_en[s] = !valid_q[s] || stage_en[s+1];
  end

  // Valid bits follow the items down the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= (valid_q & ~stage_en)
               | ({valid_q[rfe_pkg::NumStages-2:0], in_valid_i} & stage_en);
    end
  end

  assign in_ready_o  = stage_en[0];
  assign out_valid_o = valid_q[rfe_pkg::NumStages-1];

  always_comb begin
    raw_beat.sec = raw_seconds_i;
    raw_beat.min = raw_minutes_i;
    raw_beat.hr  = raw_hours_i;
    raw_beat.day = raw_day_i;
    raw_beat.mon = raw_month_i;
    raw_beat.yr  = raw_year_i;
    raw_beat.cen = raw_century_i;
  end

  rfe_decode u_decode (
    .clk_i  (clk_i),
    .en_i   (stage_en[CivilLo-1:0]),
    .cfg_i  (cfg_q),
    .raw_i  (raw_beat),
    .date_o (date)
  );

  rfe_civil u_civil (
    .clk_i   (clk_i),
    .en_i    (stage_en[ScaleLo-1:CivilLo]),
    .date_i  (date),
    .count_o (day_count)
  );

  rfe_scale u_scale (
    .clk_i     (clk_i),
    .en_i      (stage_en[rfe_pkg::NumStages-1:ScaleLo]),
    .count_i   (day_count),
    .seconds_o (epoch_seconds_o),
    .nanos_o   (epoch_scaled_nanos_o)
  );

endmodule

### hw/rtl/rfe_checker.sv
// Port-level checks for the epoch converter and their bind to the top level.
module rfe_checker (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_ready_o,
  input  logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  input  logic signed [rfe_pkg::SecW-1:0]        epoch_seconds_o,
  input  logic signed [rfe_pkg::NanosW-1:0]      epoch_scaled_nanos_o
);

  logic [rfe_pkg::SecW-1:0] nanos_low_exp;

  // The low bits of the scaled value depend only on the low seconds bits.
  assign nanos_low_exp = rfe_pkg::SecW'(epoch_seconds_o)
                       * rfe_pkg::SecW'(rfe_pkg::NanosPerSec);

  // The pipeline comes out of reset empty.
  a_empty_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !out_valid_o)
    else $error("result beat shown right after reset");

  // Input backpressure only comes from a stalled result.
  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled while the output side is free");

  // Scaled nanoseconds agree with the seconds in their low 40 bits.
  a_nanos_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (epoch_scaled_nanos_o[rfe_pkg::SecW-1:0] == nanos_low_exp))
    else $error("scaled nanoseconds disagree with epoch seconds");

  // A waiting result beat holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(epoch_seconds_o) && $stable(epoch_scaled_nanos_o)))
    else $error("stalled result beat changed");

endmodule

bind rtc_fields_to_epoch_seconds rfe_checker u_rfe_checker (.*);
